>>> design/psag_pkg.sv
package psag_pkg;

   localparam int CSR_DATA_BITS  = 11;
   localparam int CSR_INDEX_BITS = 2;
   localparam int ADDR_BITS      = 30;
   localparam int OFFSET_BITS    = 2;

   localparam logic [CSR_DATA_BITS-1:0] SIZE_RESET = 11'd1024;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SIZE_I       = 2'd0,
      CSR_SIZE_J       = 2'd1,
      CSR_SIZE_K       = 2'd2,
      CSR_STENCIL_MODE = 2'd3
   } csr_index_type;

   // sideband that travels with each neighbor down the pipe
   typedef struct packed {
      logic [OFFSET_BITS-1:0] offset_i;
      logic [OFFSET_BITS-1:0] offset_j;
      logic [OFFSET_BITS-1:0] offset_k;
      logic                   last;
      logic                   bad_coord;
   } tag_type;

endpackage

>>> design/psag_if.sv
interface psag_req_if #(
   parameter int COORD_BITS = 10
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] coord_i;
   logic [COORD_BITS-1:0] coord_j;
   logic [COORD_BITS-1:0] coord_k;

   modport source (output valid, coord_i, coord_j, coord_k, input ready);
   modport sink   (input valid, coord_i, coord_j, coord_k, output ready);
endinterface

interface psag_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [psag_pkg::ADDR_BITS-1:0]    node_address;
   logic [psag_pkg::OFFSET_BITS-1:0]  offset_i;
   logic [psag_pkg::OFFSET_BITS-1:0]  offset_j;
   logic [psag_pkg::OFFSET_BITS-1:0]  offset_k;
   logic                              last;
   logic                              bad_coord;

   modport source (output valid, node_address, offset_i, offset_j, offset_k, last, bad_coord,
                   input ready);
   modport sink   (input valid, node_address, offset_i, offset_j, offset_k, last, bad_coord,
                   output ready);
endinterface

>>> design/periodic_stencil_address_gen_top.sv
// channel   dir   transfer when          payload
// req_port  in    valid && ready         coord_i, coord_j, coord_k
// rsp_port  out   valid && ready         node_address, offset_i/j/k, last, bad_coord
// csr_*     in    csr_write_en high      csr_index, csr_write_data (no read-back)
//
// one grid point yields 27 neighbors (centered) or 8 (box), one per cycle unless rsp_port
// stalls; the next point is taken in the cycle its predecessor's last neighbor leaves the
// sequencer, so points run back to back
// first neighbor passes the sequencer and stages 1, 2, 3 and 4 before rsp_port
// reset is synchronous: sizes return to 1024, mode to centered, the pipe empties
// a stall on rsp_port freezes the sequencer and all stages together; bubbles keep their place
module periodic_stencil_address_gen_top #(
   parameter int COORD_BITS = 10
) (
   input  logic                                 clock,
   input  logic                                 reset,
   psag_req_if.sink                             req_port,
   psag_rsp_if.source                           rsp_port,
   input  logic                                 csr_write_en,
   input  logic [psag_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [psag_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);
   import psag_pkg::*;

   // widths that follow from the coordinate width
   localparam int SB     = COORD_BITS + 1;                    // effective size
   localparam int EW     = (SB > CSR_DATA_BITS) ? SB : CSR_DATA_BITS;
   localparam int WW     = SB + 1;                            // wrap arithmetic
   localparam int PJ_W   = (COORD_BITS + SB < ADDR_BITS) ? COORD_BITS + SB : ADDR_BITS;
   localparam int SIJ_W  = (2 * SB < ADDR_BITS) ? 2 * SB : ADDR_BITS;
   localparam int PK_W   = (COORD_BITS + SIJ_W < ADDR_BITS) ? COORD_BITS + SIJ_W : ADDR_BITS;
   localparam logic [EW-1:0] MAX_SIZE = EW'(1) << COORD_BITS;

   localparam logic [OFFSET_BITS-1:0] SPAN_MAX_CENTERED = 2'd2;
   localparam logic [OFFSET_BITS-1:0] SPAN_MAX_BOX      = 2'd1;

   // zero reads as one, anything above the coordinate range as the full range
   function automatic logic [SB-1:0] eff_size(input logic [CSR_DATA_BITS-1:0] raw);
      logic [EW-1:0] r;
      r = EW'(raw);
      if (r == '0)
         return SB'(1);
      else if (r > MAX_SIZE)
         return SB'(MAX_SIZE);
      else
         return SB'(r);
   endfunction

   // periodic wrap of one axis; centered positions 0..2 mean -1..+1
   function automatic logic [COORD_BITS-1:0] wrap(input logic [COORD_BITS-1:0]  c,
                                                  input logic [OFFSET_BITS-1:0] p,
                                                  input logic [SB-1:0]          s,
                                                  input logic                   box);
      logic [WW-1:0] cp;
      logic [WW-1:0] sw;
      logic [WW-1:0] res;
      cp = WW'(c) + WW'(p);
      sw = WW'(s);
      if (box) begin
         res = (cp >= sw) ? cp - sw : cp;
      end else if (cp >= sw + WW'(1)) begin
         res = cp - WW'(1) - sw;
      end else if (cp == '0) begin
         res = sw - WW'(1);
      end else begin
         res = cp - WW'(1);
      end
      return COORD_BITS'(res);
   endfunction

   // configuration registers
   logic [CSR_DATA_BITS-1:0] size_i_ff, size_j_ff, size_k_ff;
   logic                     mode_box_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_i_ff   <= SIZE_RESET;
         size_j_ff   <= SIZE_RESET;
         size_k_ff   <= SIZE_RESET;
         mode_box_ff <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_SIZE_I:       size_i_ff   <= csr_write_data;
            CSR_SIZE_J:       size_j_ff   <= csr_write_data;
            CSR_SIZE_K:       size_k_ff   <= csr_write_data;
            CSR_STENCIL_MODE: mode_box_ff <= csr_write_data[0];
            default:          ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // neighbor sequencer: holds one point and walks p (outer), q, r (inner)
   // ---------------------------------------------------------------------
   logic                   busy_ff;
   logic [COORD_BITS-1:0]  ci_ff, cj_ff, ck_ff;
   logic [SB-1:0]          si_ff, sj_ff, sk_ff;
   logic                   box_ff, bad_ff;
   logic [OFFSET_BITS-1:0] p_ff, q_ff, r_ff;

   logic [SB-1:0]          si_in, sj_in, sk_in;
   logic                   bad_in;
   logic [OFFSET_BITS-1:0] span_max;
   logic                   seq_last;
   logic                   advance;
   logic                   accept;
   logic                   rsp_valid_ff;

   // whole pipe moves unless a finished result is held back
   assign advance  = !rsp_valid_ff || rsp_port.ready;
   assign span_max = box_ff ? SPAN_MAX_BOX : SPAN_MAX_CENTERED;
   assign seq_last = busy_ff && (p_ff == span_max) && (q_ff == span_max) && (r_ff == span_max);

   assign req_port.ready = advance && (!busy_ff || seq_last);
   assign accept         = req_port.valid && req_port.ready;

   assign si_in  = eff_size(size_i_ff);
   assign sj_in  = eff_size(size_j_ff);
   assign sk_in  = eff_size(size_k_ff);
   assign bad_in = (SB'(req_port.coord_i) >= si_in) || (SB'(req_port.coord_j) >= sj_in) ||
                   (SB'(req_port.coord_k) >= sk_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (advance) begin
         if (accept)
            busy_ff <= 1'b1;
         else if (seq_last)
            busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (accept) begin
            ci_ff  <= req_port.coord_i;
            cj_ff  <= req_port.coord_j;
            ck_ff  <= req_port.coord_k;
            si_ff  <= si_in;
            sj_ff  <= sj_in;
            sk_ff  <= sk_in;
            box_ff <= mode_box_ff;
            bad_ff <= bad_in;
            p_ff   <= '0;
            q_ff   <= '0;
            r_ff   <= '0;
         end else if (busy_ff) begin
            // odometer step, r fastest
            if (r_ff != span_max) begin
               r_ff <= r_ff + OFFSET_BITS'(1);
            end else begin
               r_ff <= '0;
               if (q_ff != span_max) begin
                  q_ff <= q_ff + OFFSET_BITS'(1);
               end else begin
                  q_ff <= '0;
                  p_ff <= p_ff + OFFSET_BITS'(1);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // stage 1: wrapped neighbor coordinates
   // ---------------------------------------------------------------------
   logic                  s1_valid_ff;
   logic [COORD_BITS-1:0] s1_ni_ff, s1_nj_ff, s1_nk_ff;
   logic [SB-1:0]         s1_si_ff, s1_sj_ff;
   tag_type               s1_tag_ff, s1_tag_in;

   always_comb begin
      s1_tag_in.offset_i  = p_ff;
      s1_tag_in.offset_j  = q_ff;
      s1_tag_in.offset_k  = r_ff;
      s1_tag_in.last      = seq_last;
      s1_tag_in.bad_coord = bad_ff;
   end

   // stage 2: j term and i*j plane size
   logic                  s2_valid_ff;
   logic [COORD_BITS-1:0] s2_ni_ff, s2_nk_ff;
   logic [PJ_W-1:0]       s2_pj_ff;
   logic [SIJ_W-1:0]      s2_sij_ff;
   tag_type               s2_tag_ff;
   logic [COORD_BITS+SB-1:0] pj_full;
   logic [2*SB-1:0]          sij_full;

   assign pj_full  = (COORD_BITS + SB)'(s1_nj_ff) * (COORD_BITS + SB)'(s1_si_ff);
   assign sij_full = (2 * SB)'(s1_si_ff) * (2 * SB)'(s1_sj_ff);

   // stage 3: k term and partial sum
   logic                  s3_valid_ff;
   logic [PK_W-1:0]       s3_pk_ff;
   logic [ADDR_BITS-1:0]  s3_part_ff;
   tag_type               s3_tag_ff;
   logic [COORD_BITS+SIJ_W-1:0] pk_full;

   assign pk_full = (COORD_BITS + SIJ_W)'(s2_nk_ff) * (COORD_BITS + SIJ_W)'(s2_sij_ff);

   // stage 4: output register
   logic [ADDR_BITS-1:0]  rsp_addr_ff;
   tag_type               rsp_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= busy_ff;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ni_ff   <= wrap(ci_ff, p_ff, si_ff, box_ff);
         s1_nj_ff   <= wrap(cj_ff, q_ff, sj_ff, box_ff);
         s1_nk_ff   <= wrap(ck_ff, r_ff, sk_ff, box_ff);
         s1_si_ff   <= si_ff;
         s1_sj_ff   <= sj_ff;
         s1_tag_ff  <= s1_tag_in;

         s2_ni_ff   <= s1_ni_ff;
         s2_nk_ff   <= s1_nk_ff;
         s2_pj_ff   <= PJ_W'(pj_full);
         s2_sij_ff  <= SIJ_W'(sij_full);
         s2_tag_ff  <= s1_tag_ff;

         s3_pk_ff   <= PK_W'(pk_full);
         s3_part_ff <= ADDR_BITS'(s2_ni_ff) + ADDR_BITS'(s2_pj_ff);
         s3_tag_ff  <= s2_tag_ff;

         // sum wraps at the address width
         rsp_addr_ff <= s3_part_ff + ADDR_BITS'(s3_pk_ff);
         rsp_tag_ff  <= s3_tag_ff;
      end
   end

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.node_address = rsp_addr_ff;
   assign rsp_port.offset_i     = rsp_tag_ff.offset_i;
   assign rsp_port.offset_j     = rsp_tag_ff.offset_j;
   assign rsp_port.offset_k     = rsp_tag_ff.offset_k;
   assign rsp_port.last         = rsp_tag_ff.last;
   assign rsp_port.bad_coord    = rsp_tag_ff.bad_coord;

endmodule
